/* rtl/prc_pkg.sv */
`timescale 1ns / 1ps
package prc_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int MAX_EDGES    = 16384;

	localparam int VERT_W  = 10;
	localparam int EDGE_AW = $clog2(MAX_EDGES);
	localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
	localparam int VCNT_W  = $clog2(MAX_VERTICES + 1);
	localparam int DEG_W   = ECNT_W;
	localparam int RANK_W  = 33;
	localparam int NEXT_W  = RANK_W + $clog2(MAX_VERTICES);
	localparam int CHG_W   = 44;
	localparam int DAMP_W  = 17;
	localparam int ITER_W  = 16;
	localparam int CFG_W   = 33;
	localparam int CFG_IDX_W = 2;
	localparam int PROD_W  = RANK_W + DAMP_W;
	localparam int FRAC_SH = 16;
	localparam int DIVD_W  = PROD_W - FRAC_SH;
	localparam int DIVS_W  = (DEG_W > VCNT_W) ? DEG_W : VCNT_W;

	localparam logic [DAMP_W-1:0] ONE_Q16  = DAMP_W'(65536);
	localparam logic [RANK_W-1:0] ONE_Q32  = {1'b1, {(RANK_W-1){1'b0}}};
	localparam logic [CHG_W-1:0]  CHG_MAX  = {CHG_W{1'b1}};

	localparam logic [DAMP_W-1:0] DAMP_RST  = DAMP_W'(55706);
	localparam logic [CFG_W-1:0]  THRES_RST = CFG_W'(42950);
	localparam logic [ITER_W-1:0] LIMIT_RST = ITER_W'(100);

	localparam logic [1:0] OP_EDGE = 2'd0;
	localparam logic [1:0] OP_RUN  = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_DAMPING   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 2'd2;

	localparam logic [1:0] DIV_INIT  = 2'd0;
	localparam logic [1:0] DIV_TEL   = 2'd1;
	localparam logic [1:0] DIV_SHARE = 2'd2;

	typedef struct packed {
		logic [1:0]        op;
		logic [VERT_W-1:0] src_vertex;
		logic [VERT_W-1:0] dst_vertex;
	} in_item_t;

	typedef struct packed {
		logic [RANK_W-1:0] rank_value;
		logic              vertex_known;
		logic [ITER_W-1:0] iterations_done;
		logic              converged;
		logic              edges_dropped;
	} out_item_t;

	typedef struct packed {
		logic       req_load;
		logic       clr_wr;
		logic       idx_clr;
		logic       idx_inc;
		logic       edge_store;
		logic       set_drop;
		logic       deg_inc;
		logic       rank_rd;
		logic       run_empty;
		logic       run_start;
		logic       div_start;
		logic [1:0] div_sel;
		logic       init_load;
		logic       tel_load;
		logic       init_wr;
		logic       chg_init;
		logic       tot_clr;
		logic       conv_set;
		logic       sh_rd;
		logic       prod_load;
		logic       share_wr;
		logic       eg_rd;
		logic       eg_rd2;
		logic       eg_wr;
		logic       vx_rd;
		logic       vx_wr;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       full;
		logic       edge_empty;
		logic       last_v;
		logic       last_e;
		logic       last_clr;
		logic       go;
		logic       div_done;
		logic       out_free;
	} sts_t;

endpackage

/* rtl/pagerank_power_iteration_core.sv */
`timescale 1ns / 1ps
// An edge request is stored and its source's out-degree counted, or dropped if the edge
// memory is full; a read request passes through the rank read and the output register.
// A run request uses the 34-step serial divider for the initial and teleport ranks and
// once per vertex per iteration, and a read-modify-write of the next-rank memory per edge.
// One request is processed at a time. Reset clears all 1024 out-degree entries before the first.
module pagerank_power_iteration_core import prc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cmd_t cmd;
	sts_t sts;

	prc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	prc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

/* rtl/prc_div.sv */
`timescale 1ns / 1ps
module prc_div import prc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVD_W-1:0] dividend,
	input  logic [DIVS_W-1:0] divisor,
	output logic              done,
	output logic [DIVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIVD_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIVD_W-1:0] quo_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] dvs_q;
	logic [DIVS_W:0]   shifted;
	logic [DIVS_W:0]   rem_n;
	logic              ge;

	always_comb begin
		shifted = {rem_q, quo_q[DIVD_W-1]};
		ge      = shifted >= {1'b0, dvs_q};
		rem_n   = ge ? (shifted - {1'b0, dvs_q}) : shifted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(DIVD_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIVD_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVD_W-2:0], ge};
			rem_q <= rem_n[DIVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* rtl/prc_dp.sv */
`timescale 1ns / 1ps
module prc_dp import prc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [VERT_W-1:0] src_mem [MAX_EDGES];
	logic [VERT_W-1:0] dst_mem [MAX_EDGES];
	logic [DEG_W-1:0]  deg_mem [MAX_VERTICES];
	logic [RANK_W-1:0] rank_mem [MAX_VERTICES];
	logic [NEXT_W-1:0] next_mem [MAX_VERTICES];
	logic [RANK_W-1:0] share_mem [MAX_VERTICES];

	logic [VERT_W-1:0] src_rd_q, dst_rd_q;
	logic [DEG_W-1:0]  deg_rd_q;
	logic [RANK_W-1:0] rank_rd_q;
	logic [NEXT_W-1:0] next_rd_q;
	logic [RANK_W-1:0] share_rd_q;

	logic [DAMP_W-1:0] damp_q;
	logic [CFG_W-1:0]  thres_q;
	logic [ITER_W-1:0] limit_q;
	logic [ECNT_W-1:0] ec_q;
	logic [VCNT_W-1:0] vc_q;
	logic [ITER_W-1:0] iter_q;
	logic              conv_q;
	logic              drop_q;
	logic [CHG_W-1:0]  change_q;
	logic [EDGE_AW-1:0] idx_q;
	logic              out_valid_q;
	out_item_t         out_q;
	in_item_t          req_q;
	logic [RANK_W-1:0] init_q;
	logic [RANK_W-1:0] tel_q;
	logic [PROD_W-1:0] prod_q;
	logic [CHG_W-1:0]  tot_q;

	logic [DAMP_W-1:0] dsat;
	logic [ECNT_W-1:0] idx_p1;
	logic [VERT_W-1:0] vidx;
	logic [VERT_W-1:0] vmax;
	logic [VCNT_W-1:0] hi;
	logic [NEXT_W:0]   nv_sum;
	logic [RANK_W-1:0] nv;
	logic [RANK_W-1:0] diff;
	logic [CHG_W:0]    tot_sum;
	logic [CHG_W-1:0]  tot_n;
	logic [NEXT_W-1:0] eg_sum;
	logic              known;

	logic [DIVD_W-1:0] div_dvd;
	logic [DIVS_W-1:0] div_dvs;
	logic              div_done;
	logic [DIVD_W-1:0] div_quo;

	logic [VERT_W-1:0] rank_ra, next_ra, rank_wa, next_wa, deg_wa;
	logic              rank_re, next_re, rank_we, next_we, deg_we;
	logic [RANK_W-1:0] rank_wd;
	logic [NEXT_W-1:0] next_wd;
	logic [DEG_W-1:0]  deg_wd;

	always_comb begin
		dsat    = (damp_q > ONE_Q16) ? ONE_Q16 : damp_q;
		idx_p1  = ECNT_W'(idx_q) + ECNT_W'(1);
		vidx    = idx_q[VERT_W-1:0];
		vmax    = (req_q.src_vertex > req_q.dst_vertex) ? req_q.src_vertex : req_q.dst_vertex;
		hi      = VCNT_W'(vmax) + VCNT_W'(1);
		nv_sum  = (NEXT_W+1)'(next_rd_q) + (NEXT_W+1)'(tel_q);
		nv      = (nv_sum > (NEXT_W+1)'(ONE_Q32)) ? ONE_Q32 : nv_sum[RANK_W-1:0];
		diff    = (nv > rank_rd_q) ? (nv - rank_rd_q) : (rank_rd_q - nv);
		tot_sum = (CHG_W+1)'(tot_q) + (CHG_W+1)'(diff);
		tot_n   = (tot_sum > (CHG_W+1)'(CHG_MAX)) ? CHG_MAX : tot_sum[CHG_W-1:0];
		eg_sum  = next_rd_q + NEXT_W'(share_rd_q);
		known   = VCNT_W'(req_q.src_vertex) < vc_q;
	end

	always_comb begin
		case (cmd.div_sel)
			DIV_INIT: begin
				div_dvd = DIVD_W'(ONE_Q32);
				div_dvs = DIVS_W'(vc_q);
			end
			DIV_TEL: begin
				div_dvd = DIVD_W'({ONE_Q16 - dsat, {FRAC_SH{1'b0}}});
				div_dvs = DIVS_W'(vc_q);
			end
			default: begin
				div_dvd = prod_q[PROD_W-1:FRAC_SH];
				div_dvs = DIVS_W'(deg_rd_q);
			end
		endcase
	end

	prc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		sts.op         = req_q.op;
		sts.full       = ec_q == ECNT_W'(MAX_EDGES);
		sts.edge_empty = ec_q == '0;
		sts.last_v     = idx_p1 == ECNT_W'(vc_q);
		sts.last_e     = idx_p1 == ec_q;
		sts.last_clr   = idx_p1 == ECNT_W'(MAX_VERTICES);
		sts.go         = (iter_q < limit_q) && (change_q > CHG_W'(thres_q));
		sts.div_done   = div_done;
		sts.out_free   = !out_valid_q || out_ready;
	end

	always_comb begin
		deg_we = cmd.clr_wr || cmd.deg_inc;
		deg_wa = cmd.clr_wr ? vidx : req_q.src_vertex;
		deg_wd = cmd.clr_wr ? '0 : (deg_rd_q + DEG_W'(1));

		rank_re = cmd.rank_rd || cmd.sh_rd || cmd.vx_rd;
		rank_ra = cmd.rank_rd ? req_q.src_vertex : vidx;
		rank_we = cmd.init_wr || cmd.vx_wr;
		rank_wa = vidx;
		rank_wd = cmd.init_wr ? init_q : nv;

		next_re = cmd.eg_rd2 || cmd.vx_rd;
		next_ra = cmd.eg_rd2 ? dst_rd_q : vidx;
		next_we = cmd.sh_rd || cmd.eg_wr;
		next_wa = cmd.sh_rd ? vidx : dst_rd_q;
		next_wd = cmd.sh_rd ? '0 : eg_sum;
	end

	always_ff @(posedge clk) begin
		if (cmd.edge_store) begin
			src_mem[ec_q[EDGE_AW-1:0]] <= req_q.src_vertex;
			dst_mem[ec_q[EDGE_AW-1:0]] <= req_q.dst_vertex;
		end
		if (cmd.eg_rd) begin
			src_rd_q <= src_mem[idx_q];
			dst_rd_q <= dst_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (deg_we)
			deg_mem[deg_wa] <= deg_wd;
		if (cmd.edge_store || cmd.sh_rd)
			deg_rd_q <= deg_mem[cmd.sh_rd ? vidx : req_q.src_vertex];
	end

	always_ff @(posedge clk) begin
		if (rank_we)
			rank_mem[rank_wa] <= rank_wd;
		if (rank_re)
			rank_rd_q <= rank_mem[rank_ra];
	end

	always_ff @(posedge clk) begin
		if (next_we)
			next_mem[next_wa] <= next_wd;
		if (next_re)
			next_rd_q <= next_mem[next_ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.share_wr)
			share_mem[vidx] <= div_quo[RANK_W-1:0];
		if (cmd.eg_rd2)
			share_rd_q <= share_mem[src_rd_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			damp_q      <= DAMP_RST;
			thres_q     <= THRES_RST;
			limit_q     <= LIMIT_RST;
			ec_q        <= '0;
			vc_q        <= '0;
			iter_q      <= '0;
			conv_q      <= 1'b0;
			drop_q      <= 1'b0;
			change_q    <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_DAMPING:   damp_q  <= cfg_data[DAMP_W-1:0];
					CFG_THRESHOLD: thres_q <= cfg_data;
					CFG_LIMIT:     limit_q <= cfg_data[ITER_W-1:0];
					default: ;
				endcase
			end
			if (cmd.idx_clr)
				idx_q <= '0;
			else if (cmd.idx_inc)
				idx_q <= idx_q + EDGE_AW'(1);
			if (cmd.set_drop)
				drop_q <= 1'b1;
			if (cmd.edge_store) begin
				ec_q <= ec_q + ECNT_W'(1);
				if (hi > vc_q)
					vc_q <= hi;
			end
			if (cmd.run_start)
				iter_q <= '0;
			if (cmd.run_empty)
				conv_q <= 1'b0;
			if (cmd.chg_init)
				change_q <= CHG_W'(ONE_Q32);
			if (cmd.vx_wr && sts.last_v) begin
				change_q <= tot_n;
				iter_q   <= iter_q + ITER_W'(1);
			end
			if (cmd.conv_set)
				conv_q <= change_q <= CHG_W'(thres_q);
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.req_load)
			req_q <= in_data;
		if (cmd.init_load)
			init_q <= div_quo[RANK_W-1:0];
		if (cmd.tel_load)
			tel_q <= div_quo[RANK_W-1:0];
		if (cmd.prod_load)
			prod_q <= PROD_W'(rank_rd_q) * PROD_W'(dsat);
		if (cmd.tot_clr)
			tot_q <= '0;
		else if (cmd.vx_wr)
			tot_q <= tot_n;
		if (cmd.out_load) begin
			if (req_q.op == OP_READ) begin
				out_q.rank_value   <= known ? rank_rd_q : '0;
				out_q.vertex_known <= known;
			end else begin
				out_q.rank_value   <= '0;
				out_q.vertex_known <= 1'b0;
			end
			out_q.iterations_done <= iter_q;
			out_q.converged       <= conv_q;
			out_q.edges_dropped   <= drop_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* rtl/prc_ctrl.sv */
`timescale 1ns / 1ps
module prc_ctrl import prc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [4:0] ST_CLR    = 5'd0;
	localparam logic [4:0] ST_IDLE   = 5'd1;
	localparam logic [4:0] ST_DISP   = 5'd2;
	localparam logic [4:0] ST_E_WR   = 5'd3;
	localparam logic [4:0] ST_R_RD   = 5'd4;
	localparam logic [4:0] ST_OUT    = 5'd5;
	localparam logic [4:0] ST_DIV_I  = 5'd6;
	localparam logic [4:0] ST_DIV_T  = 5'd7;
	localparam logic [4:0] ST_INIT   = 5'd8;
	localparam logic [4:0] ST_CHK    = 5'd9;
	localparam logic [4:0] ST_SH_RD  = 5'd10;
	localparam logic [4:0] ST_SH_MUL = 5'd11;
	localparam logic [4:0] ST_SH_GO  = 5'd12;
	localparam logic [4:0] ST_SH_WT  = 5'd13;
	localparam logic [4:0] ST_EG_RD  = 5'd14;
	localparam logic [4:0] ST_EG_RD2 = 5'd15;
	localparam logic [4:0] ST_EG_WR  = 5'd16;
	localparam logic [4:0] ST_VX_RD  = 5'd17;
	localparam logic [4:0] ST_VX_WR  = 5'd18;

	logic [4:0] state_q, state_n;

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		in_ready = state_q == ST_IDLE;
		case (state_q)
			ST_CLR: begin
				cmd.clr_wr  = 1'b1;
				cmd.idx_inc = 1'b1;
				if (sts.last_clr) begin
					cmd.idx_clr = 1'b1;
					state_n     = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.req_load = 1'b1;
					state_n      = ST_DISP;
				end
			end
			ST_DISP: begin
				case (sts.op)
					OP_EDGE: begin
						if (sts.full) begin
							cmd.set_drop = 1'b1;
							state_n      = ST_IDLE;
						end else begin
							cmd.edge_store = 1'b1;
							state_n        = ST_E_WR;
						end
					end
					OP_RUN: begin
						cmd.run_start = 1'b1;
						if (sts.edge_empty) begin
							cmd.run_empty = 1'b1;
							state_n       = ST_OUT;
						end else begin
							cmd.div_start = 1'b1;
							cmd.div_sel   = DIV_INIT;
							state_n       = ST_DIV_I;
						end
					end
					OP_READ: begin
						cmd.rank_rd = 1'b1;
						state_n     = ST_R_RD;
					end
					default: state_n = ST_IDLE;
				endcase
			end
			ST_E_WR: begin
				cmd.deg_inc = 1'b1;
				state_n     = ST_IDLE;
			end
			ST_R_RD: state_n = ST_OUT;
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			ST_DIV_I: begin
				cmd.div_sel = DIV_TEL;
				if (sts.div_done) begin
					cmd.init_load = 1'b1;
					cmd.div_start = 1'b1;
					state_n       = ST_DIV_T;
				end
			end
			ST_DIV_T: begin
				if (sts.div_done) begin
					cmd.tel_load = 1'b1;
					cmd.idx_clr  = 1'b1;
					state_n      = ST_INIT;
				end
			end
			ST_INIT: begin
				cmd.init_wr = 1'b1;
				cmd.idx_inc = 1'b1;
				if (sts.last_v) begin
					cmd.chg_init = 1'b1;
					cmd.idx_clr  = 1'b1;
					state_n      = ST_CHK;
				end
			end
			ST_CHK: begin
				if (sts.go) begin
					cmd.idx_clr = 1'b1;
					cmd.tot_clr = 1'b1;
					state_n     = ST_SH_RD;
				end else begin
					cmd.conv_set = 1'b1;
					state_n      = ST_OUT;
				end
			end
			ST_SH_RD: begin
				cmd.sh_rd = 1'b1;
				state_n   = ST_SH_MUL;
			end
			ST_SH_MUL: begin
				cmd.prod_load = 1'b1;
				state_n       = ST_SH_GO;
			end
			ST_SH_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_SHARE;
				state_n       = ST_SH_WT;
			end
			ST_SH_WT: begin
				cmd.div_sel = DIV_SHARE;
				if (sts.div_done) begin
					cmd.share_wr = 1'b1;
					if (sts.last_v) begin
						cmd.idx_clr = 1'b1;
						state_n     = ST_EG_RD;
					end else begin
						cmd.idx_inc = 1'b1;
						state_n     = ST_SH_RD;
					end
				end
			end
			ST_EG_RD: begin
				cmd.eg_rd = 1'b1;
				state_n   = ST_EG_RD2;
			end
			ST_EG_RD2: begin
				cmd.eg_rd2 = 1'b1;
				state_n    = ST_EG_WR;
			end
			ST_EG_WR: begin
				cmd.eg_wr = 1'b1;
				if (sts.last_e) begin
					cmd.idx_clr = 1'b1;
					state_n     = ST_VX_RD;
				end else begin
					cmd.idx_inc = 1'b1;
					state_n     = ST_EG_RD;
				end
			end
			ST_VX_RD: begin
				cmd.vx_rd = 1'b1;
				state_n   = ST_VX_WR;
			end
			ST_VX_WR: begin
				cmd.vx_wr = 1'b1;
				if (sts.last_v) begin
					cmd.idx_clr = 1'b1;
					state_n     = ST_CHK;
				end else begin
					cmd.idx_inc = 1'b1;
					state_n     = ST_VX_RD;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLR;
		else
			state_q <= state_n;
	end

endmodule
